// ----- design/bhpq_pkg.sv -----
// Shared types and constants for the binary heap priority queue.
// Used by bhpq_cell and binary_heap_priority_queue_core; no dependencies.
`default_nettype none

package bhpq_pkg;

	localparam int BHPQ_CAPACITY   = 1024;
	localparam int BHPQ_DATA_WIDTH = 32;

	typedef enum logic {
		REQ_PUSH = 1'b0,
		REQ_POP  = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} stat_t;

	// neighbor link: a traveling sift token or a fill value for a held slot
	typedef struct packed {
		logic tok;
		logic fill;
	} lnk_t;

	// sequencer command to one level cell
	typedef struct packed {
		logic start;
		logic up;
		logic rd;
	} ctl_t;

	typedef struct packed {
		logic busy;
		logic reading;
	} cst_t;

	// rows of sibling pairs needed at one tree level
	function automatic int level_rows(input int level, input int capacity);
		int first;
		int span;
		int avail;
		first = (1 << level) - 1;
		span  = 1 << level;
		avail = capacity - first;
		if (avail > span) begin
			avail = span;
		end
		return (avail + 1) / 2;
	endfunction

endpackage

`default_nettype wire

// ----- design/binary_heap_priority_queue_core.sv -----
// Binary heap priority queue: sequencer plus a chain of per-level cells.
// Depends on bhpq_pkg, bhpq_cell and bhpq_ram.
//
//  channel | signals                                  | beat carries
//  --------+------------------------------------------+-------------------------------
//  s_axis  | s_axis_tvalid/tready/tdata/tuser         | push_value, req_type
//  m_axis  | m_axis_tvalid/tready/tdata               | top_value, top_valid, count,
//          |                                          | status
//  cfg     | cfg_valid/cfg_ready/cfg_data             | heap_order
//
// Push and pop sift through D levels, D being the tree levels the sift walks
// (at most $clog2(CAPACITY+1)); refused requests skip the sift.
// Each level costs a registered RAM read of a sibling pair and a compare in the cell.
// No clearing pass after reset: slots at or above the count are never used.
// A finished result waits in the output register; the next beat is taken meanwhile.
`default_nettype none

module binary_heap_priority_queue_core #(
	parameter int CAPACITY   = bhpq_pkg::BHPQ_CAPACITY,
	parameter int DATA_WIDTH = bhpq_pkg::BHPQ_DATA_WIDTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// push_value
	input  logic [((DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	// req_type
	input  logic [0:0] s_axis_tuser,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// top_value, top_valid, entry_count, status
	output logic [((DATA_WIDTH+$clog2(CAPACITY+1)+3+7)/8)*8-1:0] m_axis_tdata,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic cfg_data
);
	import bhpq_pkg::*;

	localparam int DW       = DATA_WIDTH;
	localparam int LEVELS   = $clog2(CAPACITY + 1);
	localparam int IW       = LEVELS - 1;
	localparam int CW       = LEVELS;
	localparam int LVW      = $clog2(LEVELS);
	localparam int OUT_BITS = DW + CW + 3;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INJ,
		S_FETCH,
		S_LAST,
		S_WAIT,
		S_ROOT,
		S_GRAB,
		S_SEND
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     cnt_q;
	logic              order_q;
	logic [DW-1:0]     val_q;
	logic [CW-1:0]     pos_q;
	stat_t             stat_q;
	logic [DW-1:0]     top_q;
	logic              out_valid_q;
	logic [OUT_W-1:0]  out_data_q;

	logic              acc;
	req_t              req;
	logic [LVW-1:0]    pos_lvl;
	logic [CW-1:0]     pos_clr;
	logic [IW-1:0]     pos_idx;
	logic [DW-1:0]     last_val;
	logic [LVW-1:0]    tgt_lvl;
	ctl_t              ctl_req;
	logic [IW-1:0]     ctl_idx;
	logic [DW-1:0]     ctl_value;
	logic              any_busy;
	logic [LEVELS-1:0] reading_vec;

	lnk_t              dn_lnk [LEVELS];
	logic [DW-1:0]     dn_val [LEVELS];
	logic [IW-1:0]     dn_idx [LEVELS];
	lnk_t              up_lnk [LEVELS];
	logic [DW-1:0]     up_val [LEVELS];
	logic [IW-1:0]     up_idx [LEVELS];
	logic [2*DW-1:0]   rdata_a [LEVELS];
	cst_t              cst [LEVELS];

	assign s_axis_tready = (state_q == S_IDLE);
	assign acc           = s_axis_tvalid && s_axis_tready;
	assign req           = req_t'(s_axis_tuser[0]);
	assign cfg_ready     = 1'b1;

	// pos_q is the one-based slot number: its top bit is the level
	always_comb begin
		pos_lvl = '0;
		for (int i = 0; i < CW; i++) begin
			if (pos_q[i]) begin
				pos_lvl = LVW'(i);
			end
		end
	end

	assign pos_clr  = pos_q & ~(CW'(1) << pos_lvl);
	assign pos_idx  = pos_clr[IW-1:0];
	assign last_val = pos_idx[0] ? rdata_a[pos_lvl][2*DW-1:DW] : rdata_a[pos_lvl][DW-1:0];

	always_comb begin
		tgt_lvl   = '0;
		ctl_req   = '0;
		ctl_idx   = '0;
		ctl_value = val_q;
		unique case (state_q)
			S_INJ: begin
				tgt_lvl       = pos_lvl;
				ctl_idx       = pos_idx;
				ctl_req.start = 1'b1;
				ctl_req.up    = 1'b1;
			end
			S_FETCH: begin
				tgt_lvl    = pos_lvl;
				ctl_idx    = pos_idx;
				ctl_req.rd = 1'b1;
			end
			S_LAST: begin
				ctl_value     = last_val;
				ctl_req.start = 1'b1;
			end
			S_ROOT: begin
				ctl_req.rd = 1'b1;
			end
			S_IDLE, S_WAIT, S_GRAB, S_SEND: begin
				ctl_req = '0;
			end
			default: ctl_req = '0;
		endcase
	end

	always_comb begin
		any_busy = 1'b0;
		for (int i = 0; i < LEVELS; i++) begin
			any_busy       = any_busy | cst[i].busy;
			reading_vec[i] = cst[i].reading;
		end
	end

	for (genvar l = 0; l < LEVELS; l++) begin : g_cell
		lnk_t          fu_lnk;
		logic [DW-1:0] fu_val;
		logic [IW-1:0] fu_idx;
		lnk_t          fd_lnk;
		logic [DW-1:0] fd_val;
		logic [IW-1:0] fd_idx;
		ctl_t          cell_ctl;

		if (l == 0) begin : g_top_end
			assign fu_lnk = '0;
			assign fu_val = '0;
			assign fu_idx = '0;
		end else begin : g_top_link
			assign fu_lnk = dn_lnk[l-1];
			assign fu_val = dn_val[l-1];
			assign fu_idx = dn_idx[l-1];
		end

		if (l == LEVELS - 1) begin : g_bot_end
			assign fd_lnk = '0;
			assign fd_val = '0;
			assign fd_idx = '0;
		end else begin : g_bot_link
			assign fd_lnk = up_lnk[l+1];
			assign fd_val = up_val[l+1];
			assign fd_idx = up_idx[l+1];
		end

		assign cell_ctl = (tgt_lvl == LVW'(l)) ? ctl_req : '0;

		bhpq_cell #(
			.DW     (DW),
			.LEVELS (LEVELS),
			.LEVEL  (l),
			.ROWS   (level_rows(l, CAPACITY))
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.order         (order_q),
			.fill_cnt      (cnt_q),
			.ctl           (cell_ctl),
			.ctl_value     (ctl_value),
			.ctl_idx       (ctl_idx),
			.from_up       (fu_lnk),
			.from_up_value (fu_val),
			.from_up_idx   (fu_idx),
			.from_dn       (fd_lnk),
			.from_dn_value (fd_val),
			.from_dn_idx   (fd_idx),
			.to_up         (up_lnk[l]),
			.to_up_value   (up_val[l]),
			.to_up_idx     (up_idx[l]),
			.to_dn         (dn_lnk[l]),
			.to_dn_value   (dn_val[l]),
			.to_dn_idx     (dn_idx[l]),
			.rdata         (rdata_a[l]),
			.stat          (cst[l])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			order_q     <= 1'b0;
			val_q       <= '0;
			pos_q       <= CW'(1);
			stat_q      <= STAT_DONE;
			top_q       <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				order_q <= cfg_data;
			end
			if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						stat_q <= STAT_DONE;
						if (req == REQ_PUSH) begin
							if (cnt_q == CW'(CAPACITY)) begin
								stat_q  <= STAT_FULL;
								state_q <= S_ROOT;
							end else begin
								val_q   <= s_axis_tdata[DW-1:0];
								pos_q   <= cnt_q + CW'(1);
								cnt_q   <= cnt_q + CW'(1);
								state_q <= S_INJ;
							end
						end else begin
							if (cnt_q == '0) begin
								stat_q  <= STAT_EMPTY;
								top_q   <= '0;
								state_q <= S_SEND;
							end else if (cnt_q == CW'(1)) begin
								cnt_q   <= '0;
								top_q   <= '0;
								state_q <= S_SEND;
							end else begin
								// last entry sits at one-based slot cnt_q
								pos_q   <= cnt_q;
								cnt_q   <= cnt_q - CW'(1);
								state_q <= S_FETCH;
							end
						end
					end
				end
				S_INJ:   state_q <= S_WAIT;
				S_FETCH: state_q <= S_LAST;
				S_LAST:  state_q <= S_WAIT;
				S_WAIT: begin
					if (!any_busy) begin
						state_q <= S_ROOT;
					end
				end
				S_ROOT:  state_q <= S_GRAB;
				S_GRAB: begin
					top_q   <= rdata_a[0][DW-1:0];
					state_q <= S_SEND;
				end
				S_SEND: begin
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q <= 1'b1;
						out_data_q  <= OUT_W'({stat_q, cnt_q, (cnt_q != '0), top_q});
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

`ifndef NO_ASSERTIONS
	a_ready_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !any_busy)
		else $error("input ready while a sift is still in flight");

	a_no_bottom_spill: assert property (@(posedge clk) disable iff (!arst_n)
		!(dn_lnk[LEVELS-1].tok || dn_lnk[LEVELS-1].fill))
		else $error("last level sent a beat below the tree");

	a_no_top_spill: assert property (@(posedge clk) disable iff (!arst_n)
		!(up_lnk[0].tok || up_lnk[0].fill))
		else $error("root level sent a beat above the tree");

	a_one_reader: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(reading_vec))
		else $error("more than one level comparing at once");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count beyond capacity");
`endif

endmodule

`default_nettype wire

// ----- design/bhpq_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bhpq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- design/bhpq_cell.sv -----
// One tree level of the heap: a RAM of sibling pairs plus the sift step logic.
// Depends on bhpq_pkg and bhpq_ram.
`default_nettype none

module bhpq_cell #(
	parameter int DW     = 32,
	parameter int LEVELS = 11,
	parameter int LEVEL  = 0,
	parameter int ROWS   = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 order,
	input  logic [LEVELS-1:0]    fill_cnt,
	input  bhpq_pkg::ctl_t       ctl,
	input  logic [DW-1:0]        ctl_value,
	input  logic [LEVELS-2:0]    ctl_idx,
	input  bhpq_pkg::lnk_t       from_up,
	input  logic [DW-1:0]        from_up_value,
	input  logic [LEVELS-2:0]    from_up_idx,
	input  bhpq_pkg::lnk_t       from_dn,
	input  logic [DW-1:0]        from_dn_value,
	input  logic [LEVELS-2:0]    from_dn_idx,
	output bhpq_pkg::lnk_t       to_up,
	output logic [DW-1:0]        to_up_value,
	output logic [LEVELS-2:0]    to_up_idx,
	output bhpq_pkg::lnk_t       to_dn,
	output logic [DW-1:0]        to_dn_value,
	output logic [LEVELS-2:0]    to_dn_idx,
	output logic [2*DW-1:0]      rdata,
	output bhpq_pkg::cst_t       stat
);
	import bhpq_pkg::*;

	localparam int IW = LEVELS - 1;
	localparam int CW = LEVELS;
	localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam logic [CW-1:0] BASE = CW'((1 << LEVEL) - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_HOLD
	} state_t;

	typedef enum logic [1:0] {
		M_START_UP,
		M_START_DN,
		M_FROM_UP,
		M_FROM_DN
	} mode_t;

	state_t          state_q;
	mode_t           mode_q;
	logic [DW-1:0]   v_q;
	logic [IW-1:0]   k_q;
	logic [IW-1:0]   hole_q;
	logic [2*DW-1:0] row_q;
	lnk_t            to_up_q;
	logic [DW-1:0]   to_up_value_q;
	logic [IW-1:0]   to_up_idx_q;
	lnk_t            to_dn_q;
	logic [DW-1:0]   to_dn_value_q;
	logic [IW-1:0]   to_dn_idx_q;

	logic [IW-1:0]   rd_row;
	logic            re;
	logic [DW-1:0]   left;
	logic [DW-1:0]   right;
	logic [CW-1:0]   glob_left;
	logic [CW-1:0]   glob_right;
	logic            left_ok;
	logic            sel_r;
	logic [DW-1:0]   best;
	logic            dn_win;
	logic [IW:0]     child_ext;
	logic [IW:0]     k_ext;
	logic            par_sel;
	logic [DW-1:0]   par;
	logic            up_win;
	logic            wr_hold;
	logic            wr_root;
	logic [DW-1:0]   fill_val;
	logic [IW-1:0]   hole_row;
	logic            we;
	logic [AW-1:0]   waddr;
	logic [2*DW-1:0] wdata;

	function automatic logic above(input logic [DW-1:0] a, input logic [DW-1:0] b,
		input logic ord);
		return ord ? ($signed(a) > $signed(b)) : ($signed(a) < $signed(b));
	endfunction

	// row address: own slot on start/direct read, children pair from above,
	// parent pair from below
	always_comb begin
		priority if (ctl.start || ctl.rd) begin
			rd_row = ctl_idx >> 1;
		end else if (from_up.tok) begin
			rd_row = from_up_idx;
		end else begin
			rd_row = from_dn_idx >> 2;
		end
	end

	assign re = ctl.start | ctl.rd | from_up.tok | from_dn.tok;

	assign left       = rdata[DW-1:0];
	assign right      = rdata[2*DW-1:DW];
	assign glob_left  = BASE + {k_q, 1'b0};
	assign glob_right = glob_left + CW'(1);
	assign left_ok    = glob_left < fill_cnt;
	assign sel_r      = (glob_right < fill_cnt) && above(right, left, order);
	assign best       = sel_r ? right : left;
	assign dn_win     = left_ok && above(best, v_q, order);
	assign child_ext  = {k_q, sel_r};

	assign k_ext   = {1'b0, k_q};
	assign par_sel = k_ext[1];
	assign par     = par_sel ? right : left;
	assign up_win  = above(v_q, par, order);

	assign wr_hold  = (state_q == S_HOLD) && (from_up.fill || from_dn.fill);
	assign wr_root  = (state_q == S_READ) && (LEVEL == 0) &&
		((mode_q == M_START_UP) || ((mode_q == M_FROM_DN) && up_win));
	assign fill_val = from_up.fill ? from_up_value : from_dn_value;
	assign hole_row = hole_q >> 1;
	assign we       = wr_hold | wr_root;

	always_comb begin
		if (wr_hold) begin
			waddr = hole_row[AW-1:0];
			wdata = hole_q[0] ? {fill_val, row_q[DW-1:0]} : {row_q[2*DW-1:DW], fill_val};
		end else begin
			waddr = '0;
			wdata = {rdata[2*DW-1:DW], v_q};
		end
	end

	bhpq_ram #(
		.WIDTH (2 * DW),
		.DEPTH (ROWS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (rd_row[AW-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			mode_q        <= M_START_UP;
			v_q           <= '0;
			k_q           <= '0;
			hole_q        <= '0;
			row_q         <= '0;
			to_up_q       <= '0;
			to_up_value_q <= '0;
			to_up_idx_q   <= '0;
			to_dn_q       <= '0;
			to_dn_value_q <= '0;
			to_dn_idx_q   <= '0;
		end else begin
			to_up_q <= '0;
			to_dn_q <= '0;
			unique case (state_q)
				S_IDLE: begin
					priority if (ctl.start) begin
						state_q <= S_READ;
						mode_q  <= ctl.up ? M_START_UP : M_START_DN;
						v_q     <= ctl_value;
						k_q     <= ctl_idx;
					end else if (from_up.tok) begin
						state_q <= S_READ;
						mode_q  <= M_FROM_UP;
						v_q     <= from_up_value;
						k_q     <= from_up_idx;
					end else if (from_dn.tok) begin
						state_q <= S_READ;
						mode_q  <= M_FROM_DN;
						v_q     <= from_dn_value;
						k_q     <= from_dn_idx;
					end
				end
				S_READ: begin
					unique case (mode_q)
						M_START_UP: begin
							if (LEVEL == 0) begin
								state_q <= S_IDLE;
							end else begin
								state_q       <= S_HOLD;
								row_q         <= rdata;
								hole_q        <= k_q;
								to_up_q.tok   <= 1'b1;
								to_up_value_q <= v_q;
								to_up_idx_q   <= k_q;
							end
						end
						M_START_DN: begin
							state_q       <= S_HOLD;
							row_q         <= rdata;
							hole_q        <= k_q;
							to_dn_q.tok   <= 1'b1;
							to_dn_value_q <= v_q;
							to_dn_idx_q   <= k_q;
						end
						M_FROM_UP: begin
							to_up_q.fill <= 1'b1;
							if (dn_win) begin
								to_up_value_q <= best;
								state_q       <= S_HOLD;
								row_q         <= rdata;
								hole_q        <= child_ext[IW-1:0];
								to_dn_q.tok   <= 1'b1;
								to_dn_value_q <= v_q;
								to_dn_idx_q   <= child_ext[IW-1:0];
							end else begin
								to_up_value_q <= v_q;
								state_q       <= S_IDLE;
							end
						end
						M_FROM_DN: begin
							to_dn_q.fill <= 1'b1;
							if (up_win) begin
								to_dn_value_q <= par;
								if (LEVEL == 0) begin
									state_q <= S_IDLE;
								end else begin
									state_q       <= S_HOLD;
									row_q         <= rdata;
									hole_q        <= k_ext[IW:1];
									to_up_q.tok   <= 1'b1;
									to_up_value_q <= v_q;
									to_up_idx_q   <= k_ext[IW:1];
								end
							end else begin
								to_dn_value_q <= v_q;
								state_q       <= S_IDLE;
							end
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_HOLD: begin
					if (from_up.fill || from_dn.fill) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign to_up       = to_up_q;
	assign to_up_value = to_up_value_q;
	assign to_up_idx   = to_up_idx_q;
	assign to_dn       = to_dn_q;
	assign to_dn_value = to_dn_value_q;
	assign to_dn_idx   = to_dn_idx_q;

	assign stat.busy    = (state_q != S_IDLE) || to_up_q.tok || to_up_q.fill ||
		to_dn_q.tok || to_dn_q.fill;
	assign stat.reading = (state_q == S_READ);

endmodule

`default_nettype wire
